// ----- rtl/core/ptuv_pkg.sv -----
// Package for the planar texture projection core: angle constants, the
// quarter-wave sine table built at elaboration, and the angle-to-trig lookup.
// No dependencies.
`default_nettype none

package ptuv_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_ROT    = 3'd0;
  localparam logic [2:0] REG_USCALE = 3'd1;
  localparam logic [2:0] REG_VSCALE = 3'd2;
  localparam logic [2:0] REG_UOFS   = 3'd3;
  localparam logic [2:0] REG_VOFS   = 3'd4;
  localparam logic [2:0] REG_TEXW   = 3'd5;
  localparam logic [2:0] REG_TEXH   = 3'd6;

  // Angle landmarks in whole degrees
  localparam logic [8:0] DEG_90  = 9'd90;
  localparam logic [8:0] DEG_180 = 9'd180;
  localparam logic [8:0] DEG_270 = 9'd270;
  localparam logic [8:0] DEG_360 = 9'd360;

  // Divisor width: |scale| (16) * size (13) << 14
  localparam int DEN_W = 43;

  localparam longint unsigned RAD_PER_DEG_Q28 = 64'd4685083;

  typedef logic [14:0] sin_tab_t [0:90];

  // Shift-subtract quotient, used only while the sine table is built
  function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Nearest Q2.14 sine of r degrees by a fixed-point Taylor series
  function automatic logic [14:0] quarter_sin(int unsigned r);
    longint unsigned x;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned dv;
    x    = longint'(r) * RAD_PER_DEG_Q28;
    term = x;
    sum  = x;
    for (int unsigned k = 1; k <= 7; k++) begin
      term = (term * x) >> 28;
      term = (term * x) >> 28;
      dv   = longint'((2 * k) * (2 * k + 1));
      term = udiv64(term, dv);
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return 15'((sum + 64'd8192) >> 14);
  endfunction

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t t;
    for (int unsigned i = 0; i <= 90; i++) begin
      t[i] = quarter_sin(i);
    end
    return t;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

  // Q2.14 sine of deg, deg in 0..359
  function automatic logic signed [15:0] trig_of(logic [8:0] deg);
    logic [1:0]  q;
    logic [6:0]  r;
    logic [6:0]  idx;
    logic signed [15:0] m;
    if (deg >= DEG_270) begin
      q = 2'd3;
      r = 7'(deg - DEG_270);
    end else if (deg >= DEG_180) begin
      q = 2'd2;
      r = 7'(deg - DEG_180);
    end else if (deg >= DEG_90) begin
      q = 2'd1;
      r = 7'(deg - DEG_90);
    end else begin
      q = 2'd0;
      r = 7'(deg);
    end
    idx = q[0] ? 7'(7'(DEG_90) - r) : r;
    m   = signed'({1'b0, SIN_TAB[idx]});
    return q[1] ? -m : m;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/planar_texture_uv_projection_core.sv -----
// Planar texture projection core: base-axis choice, rotation, scaling and a
// pipelined restoring divider per coordinate. Depends on ptuv_pkg.
//
// Channel   | Signals                                   | Transfer
// ----------+-------------------------------------------+------------------------
// command   | start, busy, vertex_x/y/z, normal_x/y/z   | start high, busy low
// result    | done, tex_u, tex_v, scale_error           | done high, one cycle
// config    | cfg_we, cfg_addr, cfg_wdata               | cfg_we high
//
// One item enters per cycle; busy is never raised. Each command passes through
// stages A to G, the restoring divider (one quotient bit per stage), stage H
// and the output register that raises done; the result is valid while done
// is high. Synchronous reset clears valid bits and sets the configuration
// registers to defaults; there is no clearing pass. The receiver cannot stall.
`default_nettype none

module planar_texture_uv_projection_core
  import ptuv_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [COORD_WIDTH-1:0] vertex_x,
  input  wire logic signed [COORD_WIDTH-1:0] vertex_y,
  input  wire logic signed [COORD_WIDTH-1:0] vertex_z,
  input  wire logic signed [15:0]            normal_x,
  input  wire logic signed [15:0]            normal_y,
  input  wire logic signed [15:0]            normal_z,
  output logic                               done,
  output logic signed [COORD_WIDTH-1:0]      tex_u,
  output logic signed [COORD_WIDTH-1:0]      tex_v,
  output logic                               scale_error,
  input  wire logic                          cfg_we,
  input  wire logic [2:0]                    cfg_addr,
  input  wire logic [15:0]                   cfg_wdata
);

  localparam int CW     = COORD_WIDTH;
  localparam int PROD_W = CW + 16;
  localparam int DU_W   = PROD_W + 1;
  localparam int NUM_W  = (DU_W + 9 > 63) ? DU_W + 9 : 63;
  localparam int MAG_W  = NUM_W - 1;
  localparam int REM_W  = DEN_W + 1;
  localparam int CMP_W  = (MAG_W > DEN_W + CW) ? MAG_W : DEN_W + CW;

  // Configuration registers
  logic [8:0]         rot;
  logic signed [15:0] scale [0:1];
  logic signed [15:0] ofs   [0:1];
  logic [12:0]        size  [0:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      rot      <= '0;
      scale[0] <= 16'sd256;
      scale[1] <= 16'sd256;
      ofs[0]   <= '0;
      ofs[1]   <= '0;
      size[0]  <= 13'd1;
      size[1]  <= 13'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ROT:    rot      <= cfg_wdata[8:0];
        REG_USCALE: scale[0] <= cfg_wdata;
        REG_VSCALE: scale[1] <= cfg_wdata;
        REG_UOFS:   ofs[0]   <= cfg_wdata;
        REG_VOFS:   ofs[1]   <= cfg_wdata;
        REG_TEXW:   size[0]  <= cfg_wdata[12:0];
        REG_TEXH:   size[1]  <= cfg_wdata[12:0];
        default:    ;
      endcase
    end
  end

  // Derived configuration: trig values, signs, divisors, offset terms, scale error
  logic signed [15:0]      cf_sin;
  logic signed [15:0]      cf_cos;
  logic                    cf_sneg [0:1];
  logic [DEN_W-1:0]        cf_den  [0:1];
  logic signed [NUM_W-1:0] cf_ofsp [0:1];
  logic                    cf_err;
  logic [8:0]              deg;
  logic [8:0]              cos_deg;

  always_comb begin
    deg     = (rot >= DEG_360) ? 9'(rot - DEG_360) : rot;
    cos_deg = (deg >= DEG_270) ? 9'(deg - DEG_270) : 9'(deg + DEG_90);
  end

  always_ff @(posedge clk) begin
    cf_sin <= trig_of(deg);
    cf_cos <= trig_of(cos_deg);
    cf_err <= (scale[0] == '0) || (scale[1] == '0);
    for (int l = 0; l < 2; l++) begin
      logic [15:0]        abs_s;
      logic [12:0]        sz;
      logic [28:0]        pr;
      logic signed [31:0] op;
      abs_s = scale[l][15] ? 16'(-scale[l]) : 16'(scale[l]);
      sz    = (size[l] == '0) ? 13'd1 : size[l];
      pr    = 29'(abs_s) * 29'(sz);
      op    = 32'(ofs[l]) * 32'(scale[l]);
      cf_sneg[l] <= scale[l][15];
      cf_den[l]  <= {pr, 14'b0};
      cf_ofsp[l] <= {{(NUM_W-62){op[31]}}, op, 30'b0};
    end
  end

  assign busy = 1'b0;

  // Stage A: capture the command
  logic                 a_vld;
  logic signed [CW-1:0] a_v [0:2];
  logic signed [15:0]   a_nx, a_ny, a_nz;

  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else     a_vld <= start && !busy;
    a_v[0] <= vertex_x;
    a_v[1] <= vertex_y;
    a_v[2] <= vertex_z;
    a_nx   <= normal_x;
    a_ny   <= normal_y;
    a_nz   <= normal_z;
  end

  // Stage B: pick the base axis, strictly greater wins, floor by default
  logic                 b_vld;
  logic signed [CW-1:0] b_s, b_t;
  logic signed [16:0]   cand [0:5];
  logic signed [16:0]   best_val;
  logic [2:0]           best;

  always_comb begin
    cand[0]  = 17'(a_nz);
    cand[1]  = -17'(a_nz);
    cand[2]  = 17'(a_nx);
    cand[3]  = -17'(a_nx);
    cand[4]  = 17'(a_ny);
    cand[5]  = -17'(a_ny);
    best_val = '0;
    best     = '0;
    for (int i = 0; i < 6; i++) begin
      if (cand[i] > best_val) begin
        best_val = cand[i];
        best     = 3'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) b_vld <= 1'b0;
    else     b_vld <= a_vld;
    b_s <= (best[2:1] == 2'd1) ? a_v[1] : a_v[0];
    b_t <= (best[2:1] == 2'd0) ? a_v[1] : a_v[2];
  end

  // Stage C: rotation products
  logic                     c_vld;
  logic signed [PROD_W-1:0] c_p [0:1][0:1];

  always_ff @(posedge clk) begin
    if (rst) c_vld <= 1'b0;
    else     c_vld <= b_vld;
    c_p[0][0] <= cf_cos * b_s;
    c_p[0][1] <= cf_sin * b_t;
    c_p[1][0] <= cf_sin * b_s;
    c_p[1][1] <= cf_cos * b_t;
  end

  // Stage D: projected sums, u adds and v subtracts
  logic                   d_vld;
  logic signed [DU_W-1:0] d_du [0:1];

  always_ff @(posedge clk) begin
    if (rst) d_vld <= 1'b0;
    else     d_vld <= c_vld;
    d_du[0] <= DU_W'(c_p[0][0]) + DU_W'(c_p[0][1]);
    d_du[1] <= DU_W'(c_p[1][0]) - DU_W'(c_p[1][1]);
  end

  // Stage E: align and add the offset term
  logic                    e_vld;
  logic signed [NUM_W-1:0] e_num [0:1];

  always_ff @(posedge clk) begin
    if (rst) e_vld <= 1'b0;
    else     e_vld <= d_vld;
    for (int l = 0; l < 2; l++) begin
      e_num[l] <= {{(NUM_W-DU_W-8){d_du[l][DU_W-1]}}, d_du[l], 8'b0} + cf_ofsp[l];
    end
  end

  // Stage F: magnitude and result sign
  logic             f_vld;
  logic [MAG_W-1:0] f_mag [0:1];
  logic             f_neg [0:1];

  always_ff @(posedge clk) begin
    if (rst) f_vld <= 1'b0;
    else     f_vld <= e_vld;
    for (int l = 0; l < 2; l++) begin
      f_mag[l] <= e_num[l][NUM_W-1] ? MAG_W'(-e_num[l]) : MAG_W'(e_num[l]);
      f_neg[l] <= e_num[l][NUM_W-1] ^ cf_sneg[l];
    end
  end

  // Stage G and divider: overflow check, then one quotient bit per stage
  logic             dv_vld [0:CW];
  logic [REM_W-1:0] dv_rem [0:CW][0:1];
  logic [CW-1:0]    dv_q   [0:CW][0:1];
  logic [CW-1:0]    dv_lo  [0:CW][0:1];
  logic             dv_neg [0:CW][0:1];
  logic             dv_sat [0:CW][0:1];

  always_ff @(posedge clk) begin
    if (rst) dv_vld[0] <= 1'b0;
    else     dv_vld[0] <= f_vld;
    for (int l = 0; l < 2; l++) begin
      dv_sat[0][l] <= CMP_W'(f_mag[l]) >= CMP_W'({cf_den[l], {CW{1'b0}}});
      dv_rem[0][l] <= REM_W'(f_mag[l] >> CW);
      dv_lo[0][l]  <= f_mag[l][CW-1:0];
      dv_q[0][l]   <= '0;
      dv_neg[0][l] <= f_neg[l];
    end
  end

  for (genvar k = 1; k <= CW; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) dv_vld[k] <= 1'b0;
      else     dv_vld[k] <= dv_vld[k-1];
    end
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [REM_W-1:0] trial;
      logic             fits;
      assign trial = {dv_rem[k-1][l][REM_W-2:0], dv_lo[k-1][l][CW-1]};
      assign fits  = trial >= REM_W'(cf_den[l]);
      // Subtract where the divisor fits, shift the quotient bit in
      always_ff @(posedge clk) begin
        dv_rem[k][l] <= fits ? REM_W'(trial - REM_W'(cf_den[l])) : trial;
        dv_q[k][l]   <= {dv_q[k-1][l][CW-2:0], fits};
        dv_lo[k][l]  <= {dv_lo[k-1][l][CW-2:0], 1'b0};
        dv_neg[k][l] <= dv_neg[k-1][l];
        dv_sat[k][l] <= dv_sat[k-1][l];
      end
    end
  end

  // Stage H: round to nearest, halves away from zero
  logic          h_vld;
  logic [CW:0]   h_q   [0:1];
  logic          h_neg [0:1];
  logic          h_sat [0:1];

  always_ff @(posedge clk) begin
    if (rst) h_vld <= 1'b0;
    else     h_vld <= dv_vld[CW];
    for (int l = 0; l < 2; l++) begin
      h_q[l]   <= (CW+1)'(dv_q[CW][l]) +
                  (CW+1)'(REM_W'(dv_rem[CW][l] << 1) >= REM_W'(cf_den[l]));
      h_neg[l] <= dv_neg[CW][l];
      h_sat[l] <= dv_sat[CW][l];
    end
  end

  // Output: saturate, apply sign, force zero on a scale error
  logic [CW:0]   lim [0:1];
  logic [CW:0]   res [0:1];
  logic [CW-1:0] fin [0:1];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      lim[l] = {2'b00, {(CW-1){1'b1}}} + (CW+1)'(h_neg[l]);
      res[l] = (h_sat[l] || (h_q[l] > lim[l])) ? lim[l] : h_q[l];
      fin[l] = h_neg[l] ? CW'(-res[l]) : CW'(res[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= h_vld;
    tex_u       <= cf_err ? '0 : fin[0];
    tex_v       <= cf_err ? '0 : fin[1];
    scale_error <= cf_err;
  end

  // Checks
  a_result_has_command: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, CW + 9))
    else $error("result without a matching command");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    done && scale_error |-> (tex_u == '0) && (tex_v == '0))
    else $error("scale error with non-zero coordinates");

  a_rem_u_below_den: assert property (@(posedge clk) disable iff (rst)
    dv_vld[CW] && !dv_sat[CW][0] && !cf_err |-> dv_rem[CW][0] < REM_W'(cf_den[0]))
    else $error("u remainder not below divisor");

  a_rem_v_below_den: assert property (@(posedge clk) disable iff (rst)
    dv_vld[CW] && !dv_sat[CW][1] && !cf_err |-> dv_rem[CW][1] < REM_W'(cf_den[1]))
    else $error("v remainder not below divisor");

endmodule

`default_nettype wire

// ----- tb/planar_texture_uv_projection_core_tb.sv -----
// Self-checking testbench for planar_texture_uv_projection_core: directed and random
// vertices under several register settings, each result checked against a local predictor.
// Depends on ptuv_pkg for the register indexes.
`timescale 1ns / 1ps

module planar_texture_uv_projection_core_tb;
  import ptuv_pkg::*;

  localparam int CW          = 32;
  localparam int LATENCY     = CW + 8;
  localparam int STALL_LIMIT = 3000;
  localparam int PHASE_ITEMS = 200;

  typedef struct {
    logic signed [CW-1:0] vx, vy, vz;
    logic signed [15:0]   nx, ny, nz;
  } vertex_t;

  typedef struct {
    logic signed [CW-1:0] u, v;
    logic                 err;
  } uv_t;

  // Predicts texture coordinates and holds those still to come
  class uv_scoreboard;
    logic [8:0]         rot;
    logic signed [15:0] usc, vsc, uofs, vofs;
    logic [12:0]        texw, texh;
    uv_t                uv_queue[$];
    int                 errors;

    function void reset_regs();
      rot = '0; usc = 16'sd256; vsc = 16'sd256; uofs = '0; vofs = '0;
      texw = 13'd1; texh = 13'd1; errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        REG_ROT:    rot = val[8:0];
        REG_USCALE: usc = val;
        REG_VSCALE: vsc = val;
        REG_UOFS:   uofs = val;
        REG_VOFS:   vofs = val;
        REG_TEXW:   texw = val[12:0];
        REG_TEXH:   texh = val[12:0];
        default: ;
      endcase
    endfunction

    // Nearest Q2.14 sine over the first quadrant, by series expansion
    function int quad_sine(int unsigned r);
      longint unsigned x, term, acc;
      x = longint'(r) * 64'd4685083;
      term = x;
      acc = x;
      for (int unsigned k = 1; k <= 7; k++) begin
        term = (term * x) >> 28;
        term = (term * x) >> 28;
        term = term / longint'((2 * k) * (2 * k + 1));
        acc = (k % 2 == 1) ? acc - term : acc + term;
      end
      return int'((acc + 64'd8192) >> 14);
    endfunction

    function int sine_deg(int d);
      int q, r, m;
      q = d / 90;
      r = d % 90;
      m = (q % 2 == 1) ? quad_sine(90 - r) : quad_sine(r);
      return (q >= 2) ? -m : m;
    endfunction

    // (a*s + b*t)/scale + ofs, over size, rounded half away and saturated
    function logic signed [CW-1:0] uv_coord(logic signed [15:0] a, logic signed [CW-1:0] s,
                                            logic signed [15:0] b, logic signed [CW-1:0] t,
                                            logic signed [15:0] scale,
                                            logic signed [15:0] ofs, logic [12:0] size);
      logic signed [127:0] aw, bw, sw, tw, scw, ow, num;
      logic [127:0] mag, den, quo, rem, lim;
      logic neg;
      aw = a; bw = b; sw = s; tw = t; scw = scale; ow = ofs;
      num = ((aw * sw + bw * tw) <<< 8) + ow * (scw <<< 30);
      if (scw < 0) begin
        num = -num;
        scw = -scw;
      end
      den = (128'(scw) << 14) * ((size == 0) ? 128'd1 : 128'(size));
      neg = num[127];
      mag = neg ? 128'(-num) : 128'(num);
      quo = mag / den;
      rem = mag % den;
      if (rem >= den - rem) quo = quo + 1;
      lim = neg ? (128'd1 << (CW - 1)) : (128'd1 << (CW - 1)) - 1;
      if (quo > lim) quo = lim;
      if (neg) quo = -quo;
      return quo[CW-1:0];
    endfunction

    // Pick the base plane, rotate its axes and queue the projected result
    function void note_vertex(vertex_t it);
      int cand[6];
      int best, bestval, deg, sn, cs;
      logic signed [CW-1:0] crd[3];
      logic signed [CW-1:0] s, t;
      uv_t r;
      cand[0] = it.nz; cand[1] = -int'(it.nz);
      cand[2] = it.nx; cand[3] = -int'(it.nx);
      cand[4] = it.ny; cand[5] = -int'(it.ny);
      best = 0;
      bestval = 0;
      for (int i = 0; i < 6; i++) begin
        if (cand[i] > bestval) begin
          bestval = cand[i];
          best = i;
        end
      end
      crd[0] = it.vx; crd[1] = it.vy; crd[2] = it.vz;
      s = (best / 2 == 1) ? crd[1] : crd[0];
      t = (best / 2 == 0) ? crd[1] : crd[2];
      if (usc == 0 || vsc == 0) begin
        r.u = '0; r.v = '0; r.err = 1'b1;
      end else begin
        deg = rot;
        if (deg >= 360) deg -= 360;
        sn = sine_deg(deg);
        cs = sine_deg(deg >= 270 ? deg - 270 : deg + 90);
        r.u = uv_coord(16'(cs), s, 16'(sn), t, usc, uofs, texw);
        r.v = uv_coord(16'(sn), s, 16'(-cs), t, vsc, vofs, texh);
        r.err = 1'b0;
      end
      uv_queue.push_back(r);
    endfunction

    function void check_uv(logic signed [CW-1:0] u, logic signed [CW-1:0] v, logic err);
      uv_t e;
      if (uv_queue.size() == 0) begin
        $display("%0t: unexpected result u=%0d v=%0d err=%0b", $time, u, v, err);
        errors++;
        return;
      end
      e = uv_queue.pop_front();
      if (u !== e.u) begin
        $display("%0t: tex_u expected %0d actual %0d", $time, e.u, u);
        errors++;
      end
      if (v !== e.v) begin
        $display("%0t: tex_v expected %0d actual %0d", $time, e.v, v);
        errors++;
      end
      if (err !== e.err) begin
        $display("%0t: scale_error expected %0b actual %0b", $time, e.err, err);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst, start, cfg_we;
  logic busy, done, scale_error;
  logic signed [CW-1:0] vertex_x, vertex_y, vertex_z, tex_u, tex_v;
  logic signed [15:0]   normal_x, normal_y, normal_z;
  logic [2:0]           cfg_addr;
  logic [15:0]          cfg_wdata;
  int                   stall_cycles;
  uv_scoreboard         sb;

  planar_texture_uv_projection_core #(.COORD_WIDTH(CW)) u_top (
    .clk, .rst, .start, .busy, .vertex_x, .vertex_y, .vertex_z,
    .normal_x, .normal_y, .normal_z, .done, .tex_u, .tex_v, .scale_error,
    .cfg_we, .cfg_addr, .cfg_wdata
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Check every result strobe
  always @(posedge clk) begin
    if (!rst && done) sb.check_uv(tex_u, tex_v, scale_error);
  end

  // Watchdog: count cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val;
    @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Drop start, wait until every result is back, then let the pipeline empty
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.uv_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic set_all(int rot, int us, int vs, int uo, int vo, int w, int h);
    drain();
    write_reg(REG_ROT, 16'(rot));
    write_reg(REG_USCALE, 16'(us));
    write_reg(REG_VSCALE, 16'(vs));
    write_reg(REG_UOFS, 16'(uo));
    write_reg(REG_VOFS, 16'(vo));
    write_reg(REG_TEXW, 16'(w));
    write_reg(REG_TEXH, 16'(h));
  endtask

  // Hold start until the transfer, then idle for a random gap, which may be zero
  task automatic send(vertex_t it);
    int pick, gap;
    @(negedge clk);
    start = 1'b1;
    vertex_x = it.vx; vertex_y = it.vy; vertex_z = it.vz;
    normal_x = it.nx; normal_y = it.ny; normal_z = it.nz;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_vertex(it);
    pick = $urandom_range(0, 99);
    gap = (pick < 60) ? 0 : (pick < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  function automatic vertex_t mk(int vx, int vy, int vz, int nx, int ny, int nz);
    vertex_t it;
    it.vx = vx; it.vy = vy; it.vz = vz;
    it.nx = 16'(nx); it.ny = 16'(ny); it.nz = 16'(nz);
    return it;
  endfunction

  function automatic vertex_t rand_vertex();
    vertex_t it;
    logic signed [CW-1:0] c[3];
    for (int i = 0; i < 3; i++) begin
      c[i] = ($urandom_range(0, 9) < 7) ? CW'($urandom)
                                         : CW'(int'($urandom_range(0, 2000000)) - 1000000);
    end
    it.vx = c[0]; it.vy = c[1]; it.vz = c[2];
    if ($urandom_range(0, 9) < 8) begin
      it.nx = 16'(int'($urandom_range(0, 32768)) - 16384);
      it.ny = 16'(int'($urandom_range(0, 32768)) - 16384);
      it.nz = 16'(int'($urandom_range(0, 32768)) - 16384);
    end else begin
      it.nx = 16'($urandom); it.ny = 16'($urandom); it.nz = 16'($urandom);
    end
    return it;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) send(rand_vertex());
  endtask

  function automatic int rand_scale();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) return 256;
    if (pick < 4) return int'($urandom_range(0, 512)) - 256;
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  initial begin
    sb = new();
    sb.reset_regs();
    rst = 1'b1; start = 1'b0; cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
    vertex_x = '0; vertex_y = '0; vertex_z = '0;
    normal_x = '0; normal_y = '0; normal_z = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: each base plane, ties, zero normal, out-of-range normals, extremes
    send(mk(65536, 131072, 196608, 0, 0, 16384));
    send(mk(65536, 131072, 196608, 0, 0, -16384));
    send(mk(65536, 131072, 196608, 16384, 0, 0));
    send(mk(65536, 131072, 196608, -16384, 0, 0));
    send(mk(65536, 131072, 196608, 0, 16384, 0));
    send(mk(65536, 131072, 196608, 0, -16384, 0));
    send(mk(12345, -6789, 4242, 0, 0, 0));
    send(mk(12345, -6789, 4242, 8000, 8000, 8000));
    send(mk(12345, -6789, 4242, -8000, -8000, -8000));
    send(mk(12345, -6789, 4242, -32768, 32767, -32768));
    send(mk(12345, -6789, 4242, 32767, -32768, 100));
    send(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 16384));
    send(mk(32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 16384));
    send(mk(32'h80000000, 32'h7fffffff, -1, 16384, 0, 0));
    send(mk(-1, 1, 0, 0, -16384, 0));
    send(mk(32768, -32768, 98304, 0, 0, 16384));
    set_all(30, 768, -384, 5, -7, 3, 7);
    send(mk(32'h7fffffff, 32'h80000000, 1, 0, 0, 16384));
    send(mk(100000, -200000, 300000, 0, 16384, 0));
    send(mk(32768, 32768, 32768, -16384, 0, 0));
    set_all(90, 1, 1, 32767, -32768, 1, 1);
    send(mk(32'h7fffffff, 32'h80000000, 0, 0, 0, 16384));
    send(mk(32'h80000000, 32'h7fffffff, 0, 0, 0, -16384));
    set_all(180, 0, 256, 3, 3, 2, 2);
    send(mk(65536, 65536, 65536, 0, 0, 16384));

    // Random phases across extreme and random settings
    set_all(270, -32768, 32767, -32768, 32767, 4096, 1);
    random_phase(PHASE_ITEMS);
    set_all(359, 32767, -32768, 32767, -32768, 0, 8191);
    random_phase(PHASE_ITEMS);
    set_all(511, 256, 0, 0, 0, 1, 1);
    random_phase(PHASE_ITEMS / 2);
    set_all(0, 256, 256, 0, 0, 1, 1);
    random_phase(PHASE_ITEMS);
    for (int p = 0; p < 5; p++) begin
      set_all($urandom_range(0, 511), rand_scale(), rand_scale(),
              int'($urandom_range(0, 65535)) - 32768, int'($urandom_range(0, 65535)) - 32768,
              $urandom_range(0, 8191), $urandom_range(1, 4096));
      random_phase(PHASE_ITEMS);
    end
    @(negedge clk);
    start = 1'b0;

    drain();
    if (sb.errors == 0 && sb.uv_queue.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/ptuv_pkg.sv
rtl/core/planar_texture_uv_projection_core.sv
tb/planar_texture_uv_projection_core_tb.sv
